// ===== src/rfsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsp_pkg: shared types and constants of the frame slot pool
// Slot count, field widths, operation, status and format codes, register
// indexes and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package rfsp_pkg;

	localparam int POOL_SLOTS = 16;
	localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	localparam int DIM_W  = 14;
	localparam int PAD_W  = DIM_W + 1;
	localparam int PROD_W = 2 * PAD_W;
	localparam int NEED_W = 31;
	localparam int REFS_W = 16;

	localparam logic [DIM_W-1:0]  DEFAULT_WIDTH_RST  = 14'd1920;
	localparam logic [DIM_W-1:0]  DEFAULT_HEIGHT_RST = 14'd1080;
	localparam logic [PAD_W-1:0]  PAD_MASK           = 15'd15;
	localparam logic [REFS_W-1:0] REFS_MAX           = '1;

	typedef enum logic [1:0] {
		MODE_ACQUIRE  = 2'd0,
		MODE_ADD_REF  = 2'd1,
		MODE_DROP_REF = 2'd2,
		MODE_RELEASE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ARG    = 3'd1,
		ST_BAD_HANDLE = 3'd2,
		ST_EXHAUSTED  = 3'd3,
		ST_SATURATED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FMT_UNKNOWN  = 2'd0,
		FMT_ARGB32   = 2'd1,
		FMT_YUV420P  = 2'd2,
		FMT_PACKED32 = 2'd3
	} fmt_t;

	typedef enum logic {
		CFG_DEFAULT_WIDTH  = 1'b0,
		CFG_DEFAULT_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic commit;
	} rfsp_cmd_t;

endpackage

// ===== src/rfsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsp_if: channel interfaces of the frame slot pool
// Request, response and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface rfsp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [3:0]  slot;
	logic [13:0] width;
	logic [13:0] height;
	logic [1:0]  format;

	modport source (output valid, mode, slot, width, height, format, input ready);
	modport sink   (input valid, mode, slot, width, height, format, output ready);
endinterface

interface rfsp_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot_taken;
	logic [15:0] refs_now;
	logic [1:0]  format_used;
	logic [29:0] buffer_bytes;
	logic        grow_buffer;
	logic [15:0] luma_stride;
	logic [13:0] chroma_stride;
	logic [28:0] u_offset;
	logic [28:0] v_offset;
	logic [4:0]  active_count;
	logic [4:0]  peak_count;

	modport source (output valid, status, slot_taken, refs_now, format_used, buffer_bytes,
		grow_buffer, luma_stride, chroma_stride, u_offset, v_offset, active_count,
		peak_count, input ready);
	modport sink   (input valid, status, slot_taken, refs_now, format_used, buffer_bytes,
		grow_buffer, luma_stride, chroma_stride, u_offset, v_offset, active_count,
		peak_count, output ready);
endinterface

interface rfsp_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [13:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rfsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsp_ctrl: sequencer of the frame slot pool
// Steps one item through capture, evaluate and commit, and owns the valid
// flag of the response register.
// ----------------------------------------------------------------------------
module rfsp_ctrl import rfsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output rfsp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.eval    = (state_q == S_EVAL);
		// commit only when the response register is free or draining now
		cmd.commit  = (state_q == S_COMMIT) && (!out_valid_q || rsp_ready);
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!out_valid_q || rsp_ready)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/rfsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsp_dp: datapath of the frame slot pool
// Holds the defaults, slot table and counters; finds the lowest free slot,
// runs the size multiply and applies one operation per commit.
// ----------------------------------------------------------------------------
module rfsp_dp import rfsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rfsp_cmd_t         cmd,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic [1:0]        in_mode,
	input  logic [3:0]        in_slot,
	input  logic [DIM_W-1:0]  in_width,
	input  logic [DIM_W-1:0]  in_height,
	input  logic [1:0]        in_format,
	output logic [2:0]        o_status,
	output logic [3:0]        o_slot_taken,
	output logic [REFS_W-1:0] o_refs_now,
	output logic [1:0]        o_format_used,
	output logic [29:0]       o_buffer_bytes,
	output logic              o_grow_buffer,
	output logic [15:0]       o_luma_stride,
	output logic [13:0]       o_chroma_stride,
	output logic [28:0]       o_u_offset,
	output logic [28:0]       o_v_offset,
	output logic [4:0]        o_active_count,
	output logic [4:0]        o_peak_count
);

	// configuration
	logic [DIM_W-1:0] dflt_w_q, dflt_h_q;

	// slot table and counters
	logic [POOL_SLOTS-1:0] busy_q;
	logic [REFS_W-1:0]     refs_q [POOL_SLOTS];
	logic [NEED_W-1:0]     bufsz_q [POOL_SLOTS];
	logic [CNT_W-1:0]      total_q, peak_q;

	// captured item
	mode_t            mode_q;
	logic [3:0]       slot_q;
	logic [DIM_W-1:0] w_q, h_q;
	fmt_t             fmt_q;

	// evaluate stage
	logic [PROD_W-1:0] prod_s1;
	logic [IDX_W-1:0]  found_s1;
	logic              any_free_s1;
	logic              valid_s1;
	logic [REFS_W-1:0] refs_s1;
	logic [NEED_W-1:0] bufsz_s1;

	// response register
	logic [2:0]        status_q;
	logic [3:0]        taken_q;
	logic [REFS_W-1:0] refs_out_q;
	logic [1:0]        fmt_out_q;
	logic [29:0]       bytes_q;
	logic              grow_q;
	logic [15:0]       lstride_q;
	logic [13:0]       cstride_q;
	logic [28:0]       uoff_q, voff_q;
	logic [CNT_W-1:0]  active_q, peak_out_q;

	logic              yuv;
	logic [PAD_W-1:0]  pw, ph, op_a, op_b;
	logic [IDX_W-1:0]  slot_idx, found, rd_idx, wr_idx;
	logic              any_free, slot_in_range;
	logic [NEED_W-1:0] need;
	logic [29:0]       voff_full;

	// commit decisions
	status_t           st;
	logic [3:0]        taken;
	logic [REFS_W-1:0] refs_o, refs_wd;
	logic              grow, do_acquire, do_free, refs_we;
	logic [CNT_W-1:0]  tot_nx, pk_nx;

	assign yuv           = (fmt_q == FMT_YUV420P);
	assign pw            = (PAD_W'(w_q) + PAD_MASK) & ~PAD_MASK;
	assign ph            = (PAD_W'(h_q) + PAD_MASK) & ~PAD_MASK;
	assign op_a          = yuv ? pw : PAD_W'(w_q);
	assign op_b          = yuv ? ph : PAD_W'(h_q);
	assign slot_in_range = (int'(slot_q) < POOL_SLOTS);
	assign slot_idx      = IDX_W'(slot_q);

	// lowest free slot
	always_comb begin
		found    = '0;
		any_free = 1'b0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				found    = IDX_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign rd_idx = (mode_q == MODE_ACQUIRE) ? found : slot_idx;
	assign wr_idx = (mode_q == MODE_ACQUIRE) ? found_s1 : slot_idx;

	// plane sizes: for YUV420P each chroma plane is a quarter of the luma plane
	assign need      = yuv ? (NEED_W'(prod_s1) + NEED_W'(prod_s1 >> 1))
	                       : NEED_W'({prod_s1, 2'b00});
	assign voff_full = 30'(prod_s1) + 30'(prod_s1 >> 2);

	always_comb begin
		st         = ST_OK;
		taken      = slot_q;
		refs_o     = '0;
		grow       = 1'b0;
		do_acquire = 1'b0;
		do_free    = 1'b0;
		refs_we    = 1'b0;
		refs_wd    = '0;
		case (mode_q)
			MODE_ACQUIRE: begin
				if (!any_free_s1) begin
					st    = ST_EXHAUSTED;
					taken = '0;
				end else begin
					grow       = (bufsz_s1 == '0) || (bufsz_s1 < need);
					do_acquire = 1'b1;
					refs_we    = 1'b1;
					refs_wd    = REFS_W'(1);
					refs_o     = REFS_W'(1);
					taken      = 4'(found_s1);
				end
			end
			MODE_ADD_REF: begin
				if (!valid_s1) begin
					st = ST_BAD_HANDLE;
				end else if (refs_s1 == REFS_MAX) begin
					st     = ST_SATURATED;
					refs_o = REFS_MAX;
				end else begin
					refs_we = 1'b1;
					refs_wd = refs_s1 + REFS_W'(1);
					refs_o  = refs_wd;
				end
			end
			MODE_DROP_REF: begin
				if (!valid_s1 || refs_s1 == '0) begin
					st     = ST_BAD_HANDLE;
					refs_o = valid_s1 ? refs_s1 : '0;
				end else begin
					refs_we = 1'b1;
					refs_wd = refs_s1 - REFS_W'(1);
					refs_o  = refs_wd;
					do_free = (refs_wd == '0);
				end
			end
			MODE_RELEASE: begin
				if (!valid_s1) begin
					st = ST_BAD_ARG;
				end else begin
					do_free = 1'b1;
					refs_we = 1'b1;
					refs_wd = '0;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase

		tot_nx = total_q;
		if (do_acquire)
			tot_nx = total_q + CNT_W'(1);
		else if (do_free && total_q != '0)
			tot_nx = total_q - CNT_W'(1);
		pk_nx = (tot_nx > peak_q) ? tot_nx : peak_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_w_q <= DEFAULT_WIDTH_RST;
			dflt_h_q <= DEFAULT_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEFAULT_WIDTH:  dflt_w_q <= cfg_data;
				CFG_DEFAULT_HEIGHT: dflt_h_q <= cfg_data;
				default:            dflt_w_q <= dflt_w_q;
			endcase
		end
	end

	// slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			total_q <= '0;
			peak_q  <= '0;
			for (int i = 0; i < POOL_SLOTS; i++) begin
				refs_q[i]  <= '0;
				bufsz_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			total_q <= tot_nx;
			peak_q  <= pk_nx;
			if (do_acquire)
				busy_q[wr_idx] <= 1'b1;
			else if (do_free)
				busy_q[wr_idx] <= 1'b0;
			if (refs_we)
				refs_q[wr_idx] <= refs_wd;
			if (grow)
				bufsz_q[wr_idx] <= need;
		end
	end

	// item capture with defaulting, then the evaluate stage
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(in_mode);
			slot_q <= in_slot;
			w_q    <= (in_width != '0) ? in_width : dflt_w_q;
			h_q    <= (in_height != '0) ? in_height : dflt_h_q;
			fmt_q  <= (fmt_t'(in_format) == FMT_UNKNOWN) ? FMT_ARGB32 : fmt_t'(in_format);
		end
		if (cmd.eval) begin
			prod_s1     <= op_a * op_b;
			found_s1    <= found;
			any_free_s1 <= any_free;
			valid_s1    <= slot_in_range && busy_q[slot_idx];
			refs_s1     <= refs_q[rd_idx];
			bufsz_s1    <= bufsz_q[rd_idx];
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= st;
			taken_q    <= taken;
			refs_out_q <= refs_o;
			active_q   <= tot_nx;
			peak_out_q <= pk_nx;
			grow_q     <= grow;
			if (do_acquire) begin
				fmt_out_q <= fmt_q;
				bytes_q   <= 30'(need);
				lstride_q <= yuv ? 16'(pw) : {w_q, 2'b00};
				cstride_q <= yuv ? 14'(pw >> 1) : '0;
				uoff_q    <= yuv ? 29'(prod_s1) : '0;
				voff_q    <= yuv ? 29'(voff_full) : '0;
			end else begin
				fmt_out_q <= FMT_ARGB32;
				bytes_q   <= '0;
				lstride_q <= '0;
				cstride_q <= '0;
				uoff_q    <= '0;
				voff_q    <= '0;
			end
		end
	end

	assign o_status        = status_q;
	assign o_slot_taken    = taken_q;
	assign o_refs_now      = refs_out_q;
	assign o_format_used   = fmt_out_q;
	assign o_buffer_bytes  = bytes_q;
	assign o_grow_buffer   = grow_q;
	assign o_luma_stride   = lstride_q;
	assign o_chroma_stride = cstride_q;
	assign o_u_offset      = uoff_q;
	assign o_v_offset      = voff_q;
	assign o_active_count  = 5'(active_q);
	assign o_peak_count    = 5'(peak_out_q);

endmodule

// ===== src/refcounted_frame_slot_pool_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_frame_slot_pool_top: reference counted frame slot pool
// Acquire, add reference, drop reference and release on a pool of frame
// slots, with plane layout and buffer growth reporting.
// ----------------------------------------------------------------------------
// One request produces one response. An item is captured at its accepting
// edge, then evaluated (free-slot search and size multiply) and committed to
// the response register, which makes its response valid. A new request is
// taken only after the item before it is committed. The request channel is open
// again right after the commit, while the response still waits to be taken;
// a second response waits in the commit step until the first one is taken.
// Register writes are always accepted and must only be issued while no
// request is in flight.
module refcounted_frame_slot_pool_top import rfsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rfsp_req_if.sink    req,
	rfsp_rsp_if.source  rsp,
	rfsp_cfg_if.sink    cfg
);

	rfsp_cmd_t cmd;

	assign cfg.ready = 1'b1;

	rfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	rfsp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.in_mode         (req.mode),
		.in_slot         (req.slot),
		.in_width        (req.width),
		.in_height       (req.height),
		.in_format       (req.format),
		.o_status        (rsp.status),
		.o_slot_taken    (rsp.slot_taken),
		.o_refs_now      (rsp.refs_now),
		.o_format_used   (rsp.format_used),
		.o_buffer_bytes  (rsp.buffer_bytes),
		.o_grow_buffer   (rsp.grow_buffer),
		.o_luma_stride   (rsp.luma_stride),
		.o_chroma_stride (rsp.chroma_stride),
		.o_u_offset      (rsp.u_offset),
		.o_v_offset      (rsp.v_offset),
		.o_active_count  (rsp.active_count),
		.o_peak_count    (rsp.peak_count)
	);

endmodule

// ===== src/rfsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsp_checker: port-level checks of the frame slot pool
// Watches the response channel for consistency of counts and layouts.
// ----------------------------------------------------------------------------
module rfsp_checker import rfsp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [3:0]  slot_taken,
	input logic [15:0] refs_now,
	input logic [29:0] buffer_bytes,
	input logic [1:0]  format_used,
	input logic [28:0] u_offset,
	input logic [4:0]  active_count,
	input logic [4:0]  peak_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	a_peak_ge_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> active_count <= peak_count)
		else $error("active count above peak count");

	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EXHAUSTED |->
			int'(active_count) == POOL_SLOTS && refs_now == '0 && slot_taken == '0)
		else $error("exhausted response with free slots or stray fields");

	a_yuv_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OK && format_used == FMT_YUV420P |->
			buffer_bytes == 30'(u_offset) + 30'(u_offset >> 1))
		else $error("YUV420P size does not match luma plane");

endmodule

bind refcounted_frame_slot_pool_top rfsp_checker u_rfsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.slot_taken   (rsp.slot_taken),
	.refs_now     (rsp.refs_now),
	.buffer_bytes (rsp.buffer_bytes),
	.format_used  (rsp.format_used),
	.u_offset     (rsp.u_offset),
	.active_count (rsp.active_count),
	.peak_count   (rsp.peak_count)
);
